// ===== hdl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants for the positional array list
// Item layouts, action and status codes, and the per-cell command word.
// ----------------------------------------------------------------------------
package pal_pkg;

  // List geometry
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Action codes
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_POP_BACK   = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_INSERT     = 3'd4;
  localparam logic [2:0] ACT_ERASE      = 3'd5;
  localparam logic [2:0] ACT_FIND       = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic [6:0]         position;
    logic signed [31:0] value;
  } pal_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [5:0] found_index;
    logic [6:0] count;
  } pal_out_t;

  // Command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_ERASE,
    CMD_MATCH,
    CMD_SCAN
  } pal_cmd_t;

  typedef struct packed {
    pal_cmd_t            cmd;
    logic [IDX_W-1:0]    pos;
    logic [DATA_W-1:0]   value;
    logic [CNT_W-1:0]    count;
  } pal_cell_ctrl_t;

endpackage

// ===== hdl/pal_cell.sv =====
// ----------------------------------------------------------------------------
// pal_cell: one list entry
// Holds one word and one match flag; shifts data and flags to and from its
// neighbors under the broadcast command.
// ----------------------------------------------------------------------------
module pal_cell
  import pal_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_idx,
  input  pal_cell_ctrl_t    ctrl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  input  logic              right_flag,
  output logic [DATA_W-1:0] data,
  output logic              flag
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              flag_r;
  logic              flag_nxt;

  // Select the next word and flag
  always_comb begin
    data_nxt = data_r;
    flag_nxt = flag_r;
    case (ctrl.cmd)
      CMD_INSERT: begin
        if (cell_idx == ctrl.pos) begin
          data_nxt = ctrl.value;
        end else if (cell_idx > ctrl.pos) begin
          data_nxt = left_data;
        end
      end
      CMD_ERASE: begin
        if (cell_idx >= ctrl.pos) begin
          data_nxt = right_data;
        end
      end
      CMD_MATCH: begin
        flag_nxt = (data_r == ctrl.value) && ({1'b0, cell_idx} < ctrl.count);
      end
      CMD_SCAN: begin
        flag_nxt = right_flag;
      end
      default: begin
      end
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    flag_r <= flag_nxt;
  end

  assign data = data_r;
  assign flag = flag_r;

endmodule

// ===== hdl/positional_array_list_top.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_top: fixed-capacity ordered list of signed words
// A row of DEPTH cells holds the list; insert and erase shift the row by
// one place, find latches match flags and walks them.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in_     | input     | in_valid / in_ready     | in_data  (pal_in_t)
//  out_    | output    | out_valid / out_ready   | out_data (pal_out_t)
//
//  Push, pop, insert and erase decode and shift, then load the output
//  register. Find latches match flags and scans up to the first match
//  (or entry count - 1 when absent): the match flags move down the
//  cell row one place a cycle toward cell 0. Find on an empty list skips the scan.
//  Reset is synchronous; it clears the state, count, scan counter and output
//  valid only, the entries are never cleared. A stalled result waits in the output
//  register while the next item is accepted and processed.
// ----------------------------------------------------------------------------
module positional_array_list_top
  import pal_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pal_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pal_out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  state_t           state_r,     state_nxt;
  logic [CNT_W-1:0] cnt_r,       cnt_nxt;
  logic [IDX_W-1:0] scan_cnt_r,  scan_cnt_nxt;
  pal_out_t         res_r,       res_nxt;
  logic             out_valid_r, out_valid_nxt;
  pal_out_t         out_data_r,  out_data_nxt;

  pal_cell_ctrl_t    ctrl;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] left_bus  [DEPTH];
  logic [DATA_W-1:0] right_bus [DEPTH];
  logic              cell_flag [DEPTH+1];
  logic              in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Build the cell row
  assign cell_flag[DEPTH] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_bus[i] = '0;
    end else begin : g_left
      assign left_bus[i] = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_bus[i] = cell_data[i];
    end else begin : g_right
      assign right_bus[i] = cell_data[i+1];
    end
    pal_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_bus[i]),
      .right_data (right_bus[i]),
      .right_flag (cell_flag[i+1]),
      .data       (cell_data[i]),
      .flag       (cell_flag[i])
    );
  end

  // Decode items, run the scan and load the output register
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    scan_cnt_nxt  = scan_cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctrl.cmd      = CMD_HOLD;
    ctrl.pos      = '0;
    ctrl.value    = in_data.value[DATA_W-1:0];
    ctrl.count    = cnt_r;

    // Drop a result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt.status      = ST_OK;
          res_nxt.found       = 1'b0;
          res_nxt.found_index = '0;
          state_nxt           = S_EMIT;
          case (in_data.action)
            ACT_PUSH_BACK: begin
              if (cnt_r == FULL_CNT) begin
                res_nxt.status = ST_FULL;
              end else begin
                ctrl.cmd = CMD_INSERT;
                ctrl.pos = cnt_r[IDX_W-1:0];
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            ACT_PUSH_FRONT: begin
              if (cnt_r == FULL_CNT) begin
                res_nxt.status = ST_FULL;
              end else begin
                ctrl.cmd = CMD_INSERT;
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            ACT_POP_BACK: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            ACT_POP_FRONT: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                ctrl.cmd = CMD_ERASE;
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            ACT_INSERT: begin
              if (in_data.position > cnt_r) begin
                res_nxt.status = ST_BADPOS;
              end else if (cnt_r == FULL_CNT) begin
                res_nxt.status = ST_FULL;
              end else begin
                ctrl.cmd = CMD_INSERT;
                ctrl.pos = in_data.position[IDX_W-1:0];
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            ACT_ERASE: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else if (in_data.position >= cnt_r) begin
                res_nxt.status = ST_BADPOS;
              end else begin
                ctrl.cmd = CMD_ERASE;
                ctrl.pos = in_data.position[IDX_W-1:0];
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            ACT_FIND: begin
              if (cnt_r != '0) begin
                ctrl.cmd     = CMD_MATCH;
                scan_cnt_nxt = '0;
                state_nxt    = S_SCAN;
              end
            end
            default: begin
            end
          endcase
          res_nxt.count = cnt_nxt;
        end
      end
      S_SCAN: begin
        if (cell_flag[0]) begin
          res_nxt.found       = 1'b1;
          res_nxt.found_index = scan_cnt_r;
          state_nxt           = S_EMIT;
        end else if ({1'b0, scan_cnt_r} == cnt_r - 1'b1) begin
          state_nxt = S_EMIT;
        end else begin
          ctrl.cmd     = CMD_SCAN;
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, count and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Count never exceeds capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count above capacity");

  // Count moves only with an accepted item
  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> cnt_r == $past(cnt_r))
    else $error("entry count changed without an item");

  // Scan stays inside the live entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> {1'b0, scan_cnt_r} < cnt_r)
    else $error("scan ran past the entry count");

  // Non-find items go straight to the output stage
  a_direct_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.action != ACT_FIND |=> state_r == S_EMIT)
    else $error("non-find item did not go to emit");

  // A found result always carries ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.found |-> out_data_r.status == ST_OK)
    else $error("found flag with error status");

endmodule

// ===== tb/sv/tb_positional_array_list_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_array_list_top: self-checking bench for the array list
// A queue-fed driver offers list requests and predicts each result at the
// handshake; a monitor compares every result against the oldest prediction.
// Grow and shrink phases push the list to full and back to empty, with
// random idling on both channels and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb_positional_array_list_top;
  import pal_pkg::*;

  localparam logic [2:0] ACT_NOP    = 3'd7;
  localparam int         RAND_ITEMS = 1400;
  localparam int         GROW_BLOCK = 200;
  localparam int         HOLD_AT    = 1100;
  localparam int         HOLD_LEN   = 400;
  localparam int         DRAIN_CYC  = 80;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pal_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pal_out_t out_data;

  // Predicted list contents
  logic signed [DATA_W-1:0] list_words [DEPTH];
  int                       list_len = 0;

  pal_in_t  request_queue [$];
  pal_out_t pending_results [$];
  int       sent_items = 0;
  int       results_seen = 0;
  int       error_count = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  int       traffic_phase;

  positional_array_list_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver busy, then sender busy, then no idling at all
  always_comb begin
    if (sent_items < RAND_ITEMS / 3) begin
      traffic_phase = 0;
    end else if (sent_items < 2 * RAND_ITEMS / 3) begin
      traffic_phase = 1;
    end else begin
      traffic_phase = 2;
    end
  end

  // Place a word at pos, shifting the entry there and later ones up
  function automatic logic [1:0] put_word(int pos, logic signed [DATA_W-1:0] w);
    if (pos > list_len) return ST_BADPOS;
    if (list_len >= DEPTH) return ST_FULL;
    for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
    list_words[pos] = w;
    list_len++;
    return ST_OK;
  endfunction

  // Remove the word at pos, shifting later entries down
  function automatic logic [1:0] take_word(int pos);
    if (list_len == 0) return ST_EMPTY;
    if (pos >= list_len) return ST_BADPOS;
    for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
    list_len--;
    return ST_OK;
  endfunction

  function automatic pal_out_t apply_request(pal_in_t req);
    pal_out_t rsp;
    rsp = '0;
    case (req.action)
      ACT_PUSH_BACK:  rsp.status = put_word(list_len, req.value);
      ACT_PUSH_FRONT: rsp.status = put_word(0, req.value);
      ACT_POP_BACK: begin
        rsp.status = (list_len == 0) ? ST_EMPTY : take_word(list_len - 1);
      end
      ACT_POP_FRONT:  rsp.status = take_word(0);
      ACT_INSERT:     rsp.status = put_word(int'(req.position), req.value);
      ACT_ERASE:      rsp.status = take_word(int'(req.position));
      ACT_FIND: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_words[i] == req.value) begin
            rsp.found       = 1'b1;
            rsp.found_index = i[5:0];
            break;
          end
        end
      end
      default: ;
    endcase
    rsp.count = list_len[6:0];
    return rsp;
  endfunction

  function automatic pal_in_t make_req(logic [2:0] act, int pos, logic [31:0] val);
    pal_in_t req;
    req.action   = act;
    req.position = pos[6:0];
    req.value    = val;
    return req;
  endfunction

  // Driver: predict on acceptance, then offer the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results.push_back(apply_request(in_data));
        sent_items++;
      end
      if (!in_valid || in_ready) begin
        if (request_queue.size() > 0 &&
            !(traffic_phase == 0 && $urandom_range(0, 99) < 33) &&
            !(traffic_phase == 1 && $urandom_range(0, 99) < 61)) begin
          in_valid <= 1'b1;
          in_data  <= request_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result, then choose the next ready level
  always @(posedge clk) begin
    pal_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d count %0d", out_data.status,
                 out_data.count);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            error_count++;
          end
          if (out_data.found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d", want.found_index,
                   out_data.found_index);
            error_count++;
          end
          if (out_data.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_data.count);
            error_count++;
          end
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        out_ready <= 1'b0;
      end else if (traffic_phase == 0) begin
        out_ready <= ($urandom_range(0, 99) >= 61);
      end else if (traffic_phase == 1) begin
        out_ready <= ($urandom_range(0, 99) >= 33);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int  roll;
    int  pos;
    logic [2:0]  act;
    logic [31:0] val;
    logic [31:0] extremes [4];
    logic        grow;

    extremes      = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000};

    // Directed: empty-list misuse, extremes, bad positions, find cases
    request_queue.push_back(make_req(ACT_POP_BACK, 0, 32'h0));
    request_queue.push_back(make_req(ACT_POP_FRONT, 0, 32'h0));
    request_queue.push_back(make_req(ACT_ERASE, 0, 32'h0));
    request_queue.push_back(make_req(ACT_FIND, 0, 32'h0));
    request_queue.push_back(make_req(ACT_INSERT, 1, 32'h1));
    request_queue.push_back(make_req(ACT_PUSH_BACK, 0, 32'h7FFF_FFFF));
    request_queue.push_back(make_req(ACT_PUSH_FRONT, 0, 32'h8000_0000));
    request_queue.push_back(make_req(ACT_PUSH_BACK, 0, 32'hFFFF_FFFF));
    request_queue.push_back(make_req(ACT_PUSH_BACK, 0, 32'h0));
    request_queue.push_back(make_req(ACT_INSERT, 2, 32'h5));
    request_queue.push_back(make_req(ACT_INSERT, 0, 32'h5555_5555));
    request_queue.push_back(make_req(ACT_INSERT, 6, 32'hAAAA_AAAA));
    request_queue.push_back(make_req(ACT_INSERT, 127, 32'h3));
    request_queue.push_back(make_req(ACT_ERASE, 7, 32'h0));
    request_queue.push_back(make_req(ACT_ERASE, 127, 32'h0));
    request_queue.push_back(make_req(ACT_FIND, 0, 32'hFFFF_FFFF));
    request_queue.push_back(make_req(ACT_FIND, 0, 32'h8000_0000));
    request_queue.push_back(make_req(ACT_FIND, 0, 32'hAAAA_AAAA));
    request_queue.push_back(make_req(ACT_FIND, 0, 32'd12345));
    request_queue.push_back(make_req(ACT_ERASE, 3, 32'h0));
    request_queue.push_back(make_req(ACT_POP_FRONT, 0, 32'h0));
    request_queue.push_back(make_req(ACT_POP_BACK, 0, 32'h0));
    request_queue.push_back(make_req(ACT_NOP, 127, 32'hDEAD_BEEF));
    request_queue.push_back(make_req(ACT_ERASE, 0, 32'h0));
    request_queue.push_back(make_req(ACT_FIND, 0, 32'h5555_5555));

    // Random: alternate grow and shrink blocks to reach full and empty
    for (int k = 0; k < RAND_ITEMS; k++) begin
      grow = ((k / GROW_BLOCK) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (grow) begin
        if      (roll < 25) act = ACT_PUSH_BACK;
        else if (roll < 45) act = ACT_PUSH_FRONT;
        else if (roll < 65) act = ACT_INSERT;
        else if (roll < 73) act = ACT_POP_BACK;
        else if (roll < 81) act = ACT_POP_FRONT;
        else if (roll < 88) act = ACT_ERASE;
        else if (roll < 98) act = ACT_FIND;
        else                act = ACT_NOP;
      end else begin
        if      (roll < 8)  act = ACT_PUSH_BACK;
        else if (roll < 14) act = ACT_PUSH_FRONT;
        else if (roll < 22) act = ACT_INSERT;
        else if (roll < 42) act = ACT_POP_BACK;
        else if (roll < 60) act = ACT_POP_FRONT;
        else if (roll < 80) act = ACT_ERASE;
        else if (roll < 98) act = ACT_FIND;
        else                act = ACT_NOP;
      end
      roll = $urandom_range(0, 9);
      if      (roll < 7)  pos = $urandom_range(0, 64);
      else if (roll == 7) pos = $urandom_range(0, 127);
      else if (roll == 8) pos = 0;
      else                pos = $urandom_range(60, 64);
      // Draw from a small pool often so that find hits
      roll = $urandom_range(0, 9);
      if      (roll < 4)  val = $urandom_range(0, 7);
      else if (roll == 4) val = extremes[$urandom_range(0, 3)];
      else                val = $urandom();
      request_queue.push_back(make_req(act, pos, val));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() > 0 || in_valid) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
